// File: hw/rtl/jsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jsv_pkg;

  localparam int MaxNesting = 128;
  localparam int LevelBits = $clog2(MaxNesting + 1);
  localparam int StackIdxBits = $clog2(MaxNesting);
  localparam int OffsetBits = 32;

  typedef enum logic [4:0] {
    E_NONE       = 5'd0,
    E_TRAILING   = 5'd1,
    E_DEPTH      = 5'd2,
    E_KEYWORD    = 5'd3,
    E_NUMBER     = 5'd4,
    E_FRACTION   = 5'd5,
    E_EXPONENT   = 5'd6,
    E_HEX        = 5'd7,
    E_QUOTE      = 5'd8,
    E_UNTERM     = 5'd9,
    E_ESC_END    = 5'd10,
    E_SURROGATE  = 5'd11,
    E_LOW_SURR   = 5'd12,
    E_ESCAPE     = 5'd13,
    E_ARR_SEP    = 5'd14,
    E_COLON      = 5'd15,
    E_OBJ_SEP    = 5'd16
  } err_t;

  localparam logic [1:0] KW_TRUE = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL = 2'd2;

  // Expected byte of keyword sel at index idx; zero past the end.
  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (sel)
      KW_TRUE: begin
        case (idx)
          3'd0: r = "t";
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (idx)
          3'd0: r = "f";
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'h00;
        endcase
      end
      KW_NULL: begin
        case (idx)
          3'd0: r = "n";
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    logic [2:0] r;
    case (sel)
      KW_FALSE: r = 3'd5;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/json_syntax_validator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   kind, byte_value
// result    out        out_valid/out_stall done_res, accepted, error_kind, error_offset
// config    in         APB                 depth_limit at address 0
//
// One item is taken per cycle unless the result is stalled; its result is in
// the output register in the next cycle; the lexer state register sets this.
// Reset is synchronous and returns the document state and depth_limit to 128.
// A stalled result holds; a new item is taken whenever the result register is
// empty or being emptied in the same cycle.
module json_syntax_validator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  byte_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             done_res,
  output logic             accepted,
  output logic [4:0]       error_kind,
  output logic [31:0]      error_offset,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [4:0] {
    P_VALUE, P_END, P_ARR_FIRST, P_ARR_NEXT, P_OBJ_FIRST, P_OBJ_KEY,
    P_OBJ_COLON, P_OBJ_NEXT, P_KW, P_N_SIGN, P_N_INT, P_N_FRAC0, P_N_FRAC,
    P_N_EXP0, P_N_EXPS, P_N_EXP, P_S_BODY, P_S_ESC, P_S_HEX, P_S_HEXLO,
    P_S_SURR_BS, P_S_SURR_U
  } phase_t;

  localparam logic [1:0] ADDR_DEPTH_LIMIT = 2'd0;
  localparam logic [31:0] OFF_MAX = '1;

  logic [7:0] depth_limit;
  logic stack [jsv_pkg::MaxNesting];
  logic [jsv_pkg::LevelBits-1:0] level, level_next;
  phase_t phase, phase_next;
  logic [31:0] byte_count;
  logic [15:0] hex_acc, hex_acc_next;
  logic [2:0] hex_seen, hex_seen_next;
  logic [31:0] kw_start, kw_start_next;
  logic [4:0] err, err_next;
  logic [31:0] err_off, err_off_next;
  logic is_key, is_key_next;
  logic [1:0] kw_sel, kw_sel_next;
  logic [2:0] kw_idx, kw_idx_next;
  logic push;
  logic pop;
  logic [jsv_pkg::StackIdxBits-1:0] push_idx;
  logic push_obj;

  // The two innermost container kinds are kept in registers; the stack array
  // is read one level further down with registered data.
  logic top_kind;
  logic below_kind;
  logic stack_rd;
  logic [jsv_pkg::LevelBits-1:0] level_upd;

  logic take;
  logic c_ws, c_dig, c_end;
  logic [7:0] c;
  logic [31:0] pos, pos_inc;
  logic [8:0] lim;
  logic top_obj;
  logic [4:0] hv;
  logic [15:0] hacc;
  logic cfg_wr;

  assign take = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DEPTH_LIMIT) ? {24'd0, depth_limit} : 32'd0;

  assign c = byte_value;
  assign c_end = kind;
  assign pos = byte_count;
  assign pos_inc = (byte_count == OFF_MAX) ? OFF_MAX : byte_count + 32'd1;
  assign c_ws = !c_end && (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D);
  assign c_dig = !c_end && c >= "0" && c <= "9";
  assign lim = (depth_limit > 8'(jsv_pkg::MaxNesting)) ? 9'(jsv_pkg::MaxNesting)
                                                       : {1'b0, depth_limit};
  assign top_obj = (level == '0) ? 1'b0 : top_kind;

  always_comb begin
    hv = 5'h10;
    if (!c_end) begin
      if (c >= "0" && c <= "9") hv = {1'b0, 4'(c - "0")};
      else if (c >= "a" && c <= "f") hv = {1'b0, 4'(c - "a" + 8'd10)};
      else if (c >= "A" && c <= "F") hv = {1'b0, 4'(c - "A" + 8'd10)};
    end
  end
  assign hacc = {hex_acc[11:0], hv[3:0]};

  // Lexer step. Number endings re-run the delimiter in the container phase,
  // which is inlined here as the after-value phase evaluation.
  always_comb begin
    logic [4:0] fk;
    logic [31:0] fo;
    logic vd;
    logic sv;
    logic cl;
    phase_t after;
    logic [jsv_pkg::LevelBits-1:0] lvl_c;
    logic obj_c;
    fk = jsv_pkg::E_NONE;
    fo = pos;
    vd = 1'b0;
    sv = 1'b0;
    cl = 1'b0;
    phase_next = phase;
    level_next = level;
    hex_acc_next = hex_acc;
    hex_seen_next = hex_seen;
    kw_start_next = kw_start;
    is_key_next = is_key;
    kw_sel_next = kw_sel;
    kw_idx_next = kw_idx;
    push = 1'b0;
    push_idx = jsv_pkg::StackIdxBits'(level);
    push_obj = (c == "{");
    after = P_END;
    lvl_c = level;
    obj_c = top_obj;

    case (phase)
      P_VALUE: if (!c_ws) sv = 1'b1;
      P_END: if (!c_end && !c_ws) fk = jsv_pkg::E_TRAILING;
      P_ARR_FIRST: begin
        if (!c_ws) begin
          if (!c_end && c == "]") cl = 1'b1;
          else sv = 1'b1;
        end
      end
      P_ARR_NEXT: begin
        if (!c_ws) begin
          if (!c_end && c == "]") cl = 1'b1;
          else if (!c_end && c == ",") phase_next = P_VALUE;
          else fk = jsv_pkg::E_ARR_SEP;
        end
      end
      P_OBJ_FIRST, P_OBJ_KEY: begin
        if (!c_ws) begin
          if (!c_end && c == "}" && phase == P_OBJ_FIRST) cl = 1'b1;
          else if (!c_end && c == "\"") begin
            is_key_next = 1'b1;
            phase_next = P_S_BODY;
          end else fk = jsv_pkg::E_QUOTE;
        end
      end
      P_OBJ_COLON: begin
        if (!c_ws) begin
          if (!c_end && c == ":") phase_next = P_VALUE;
          else fk = jsv_pkg::E_COLON;
        end
      end
      P_OBJ_NEXT: begin
        if (!c_ws) begin
          if (!c_end && c == "}") cl = 1'b1;
          else if (!c_end && c == ",") phase_next = P_OBJ_KEY;
          else fk = jsv_pkg::E_OBJ_SEP;
        end
      end
      P_KW: begin
        if (c_end || kw_idx >= jsv_pkg::kw_len(kw_sel) ||
            c != jsv_pkg::kw_char(kw_sel, kw_idx)) begin
          fk = jsv_pkg::E_KEYWORD;
          fo = kw_start;
        end else begin
          kw_idx_next = kw_idx + 3'd1;
          if (kw_idx + 3'd1 == jsv_pkg::kw_len(kw_sel)) vd = 1'b1;
        end
      end
      P_N_SIGN: begin
        if (c_dig) phase_next = P_N_INT;
        else fk = jsv_pkg::E_NUMBER;
      end
      P_N_INT, P_N_FRAC, P_N_EXP: begin
        if (c_dig) begin
        end else if (!c_end && c == "." && phase == P_N_INT) phase_next = P_N_FRAC0;
        else if (!c_end && (c == "e" || c == "E") && phase != P_N_EXP)
          phase_next = P_N_EXP0;
        else begin
          // Value ends; the same byte goes to the enclosing phase.
          if (level == '0) begin
            if (!c_end && !c_ws) fk = jsv_pkg::E_TRAILING;
            phase_next = P_END;
          end else if (top_obj) begin
            phase_next = P_OBJ_NEXT;
            if (!c_ws) begin
              if (!c_end && c == "}") cl = 1'b1;
              else if (!c_end && c == ",") phase_next = P_OBJ_KEY;
              else fk = jsv_pkg::E_OBJ_SEP;
            end
          end else begin
            phase_next = P_ARR_NEXT;
            if (!c_ws) begin
              if (!c_end && c == "]") cl = 1'b1;
              else if (!c_end && c == ",") phase_next = P_VALUE;
              else fk = jsv_pkg::E_ARR_SEP;
            end
          end
        end
      end
      P_N_FRAC0: begin
        if (c_dig) phase_next = P_N_FRAC;
        else fk = jsv_pkg::E_FRACTION;
      end
      P_N_EXP0: begin
        if (!c_end && (c == "+" || c == "-")) phase_next = P_N_EXPS;
        else if (c_dig) phase_next = P_N_EXP;
        else fk = jsv_pkg::E_EXPONENT;
      end
      P_N_EXPS: begin
        if (c_dig) phase_next = P_N_EXP;
        else fk = jsv_pkg::E_EXPONENT;
      end
      P_S_BODY: begin
        if (c_end) fk = jsv_pkg::E_UNTERM;
        else if (c == "\"") begin
          if (is_key) phase_next = P_OBJ_COLON;
          else vd = 1'b1;
        end else if (c == "\\") phase_next = P_S_ESC;
      end
      P_S_ESC: begin
        if (c_end) fk = jsv_pkg::E_ESC_END;
        else if (c == "u") begin
          hex_acc_next = '0;
          hex_seen_next = '0;
          phase_next = P_S_HEX;
        end else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                     c == "n" || c == "r" || c == "t") phase_next = P_S_BODY;
        else begin
          fk = jsv_pkg::E_ESCAPE;
          fo = pos_inc;
        end
      end
      P_S_HEX, P_S_HEXLO: begin
        if (hv[4]) fk = jsv_pkg::E_HEX;
        else begin
          hex_acc_next = hacc;
          hex_seen_next = hex_seen + 3'd1;
          if (hex_seen == 3'd3) begin
            if (phase == P_S_HEX) begin
              phase_next = (hacc >= 16'hD800 && hacc <= 16'hDBFF) ? P_S_SURR_BS
                                                                  : P_S_BODY;
            end else if (hacc < 16'hDC00 || hacc > 16'hDFFF) begin
              fk = jsv_pkg::E_LOW_SURR;
              fo = pos_inc;
            end else phase_next = P_S_BODY;
          end
        end
      end
      P_S_SURR_BS: begin
        if (!c_end && c == "\\") phase_next = P_S_SURR_U;
        else fk = jsv_pkg::E_SURROGATE;
      end
      P_S_SURR_U: begin
        if (!c_end && c == "u") begin
          hex_acc_next = '0;
          hex_seen_next = '0;
          phase_next = P_S_HEXLO;
        end else fk = jsv_pkg::E_SURROGATE;
      end
      default: phase_next = P_VALUE;
    endcase

    if (sv) begin
      if ({1'b0, level} + 9'd1 > lim) fk = jsv_pkg::E_DEPTH;
      else if (c_end) fk = jsv_pkg::E_NUMBER;
      else if (c == "{" || c == "[") begin
        push = 1'b1;
        level_next = level + 1'b1;
        phase_next = (c == "{") ? P_OBJ_FIRST : P_ARR_FIRST;
      end else if (c == "\"") begin
        is_key_next = 1'b0;
        phase_next = P_S_BODY;
      end else if (c == "t" || c == "f" || c == "n") begin
        kw_sel_next = (c == "t") ? jsv_pkg::KW_TRUE
                    : (c == "f") ? jsv_pkg::KW_FALSE : jsv_pkg::KW_NULL;
        kw_idx_next = 3'd1;
        kw_start_next = pos;
        phase_next = P_KW;
      end else if (c == "-") phase_next = P_N_SIGN;
      else if (c_dig) phase_next = P_N_INT;
      else fk = jsv_pkg::E_NUMBER;
    end

    if (cl) begin
      if (level != '0) lvl_c = level - 1'b1;
      level_next = lvl_c;
      obj_c = (lvl_c == '0) ? 1'b0 : below_kind;
      vd = 1'b1;
    end
    if (vd) begin
      if (lvl_c == '0) after = P_END;
      else after = obj_c ? P_OBJ_NEXT : P_ARR_NEXT;
      phase_next = after;
    end

    err_next = err;
    err_off_next = err_off;
    if (err == jsv_pkg::E_NONE && fk != jsv_pkg::E_NONE) begin
      err_next = fk;
      err_off_next = fo;
    end
    pop = cl;
    if (err != jsv_pkg::E_NONE) begin
      push = 1'b0;
      pop = 1'b0;
    end
  end

  always_comb begin
    level_upd = level;
    if (take) begin
      if (c_end) level_upd = '0;
      else if (err == jsv_pkg::E_NONE) level_upd = level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 8'd128;
    end else if (cfg_wr && paddr == ADDR_DEPTH_LIMIT) begin
      depth_limit <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (take && push) stack[push_idx] <= push_obj;
    stack_rd <= stack[jsv_pkg::StackIdxBits'(level_upd - jsv_pkg::LevelBits'(3))];
  end

  always_ff @(posedge clk) begin
    if (take && !c_end && push) begin
      top_kind <= push_obj;
      below_kind <= top_kind;
    end else if (take && !c_end && pop) begin
      top_kind <= below_kind;
      below_kind <= stack_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_VALUE;
      level <= '0;
      byte_count <= '0;
      hex_acc <= '0;
      hex_seen <= '0;
      kw_start <= '0;
      err <= jsv_pkg::E_NONE;
      err_off <= '0;
      is_key <= 1'b0;
      kw_sel <= '0;
      kw_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= take || (out_valid && out_stall);
      if (take) begin
        done_res <= c_end;
        accepted <= c_end && err_next == jsv_pkg::E_NONE;
        error_kind <= c_end ? err_next : 5'd0;
        error_offset <= (c_end && err_next != jsv_pkg::E_NONE) ? err_off_next : 32'd0;
        if (c_end) begin
          phase <= P_VALUE;
          level <= '0;
          byte_count <= '0;
          hex_acc <= '0;
          hex_seen <= '0;
          kw_start <= '0;
          err <= jsv_pkg::E_NONE;
          err_off <= '0;
          is_key <= 1'b0;
          kw_sel <= '0;
          kw_idx <= '0;
        end else begin
          byte_count <= pos_inc;
          err <= err_next;
          err_off <= err_off_next;
          if (err == jsv_pkg::E_NONE) begin
            phase <= phase_next;
            level <= level_next;
            hex_acc <= hex_acc_next;
            hex_seen <= hex_seen_next;
            kw_start <= kw_start_next;
            is_key <= is_key_next;
            kw_sel <= kw_sel_next;
            kw_idx <= kw_idx_next;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/jsv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module jsv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        kind,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        done_res,
  input wire logic        accepted,
  input wire logic [4:0]  error_kind,
  input wire logic [31:0] error_offset
);

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted transfer produced no result.");

  a_byte_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> !accepted && error_kind == 5'd0 && error_offset == 32'd0)
    else $error("Byte result carries verdict fields.");

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> accepted == (error_kind == 5'd0))
    else $error("Accept flag disagrees with error kind.");

  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> done_res == $past(kind))
    else $error("Result type does not match item type.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(error_kind))
    else $error("Stalled result changed.");

endmodule

bind json_syntax_validator_top jsv_checker u_jsv_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
  .out_valid(out_valid), .out_stall(out_stall), .done_res(done_res),
  .accepted(accepted), .error_kind(error_kind), .error_offset(error_offset)
);
`default_nettype wire
